[rtl/scw_pkg.sv]
// Shared types, constants and sizing helpers for the scaled window correlator.
package scw_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int TAP_BITS      = 16;
  localparam int CFG_TAPS      = 8;
  localparam int SCALE_BITS    = 8;
  localparam int RES_BITS      = 32;
  localparam int TAP_CNT_BITS  = 4;

  // Gain is scale/100 applied to a Q2.14 tap product
  localparam int SCALE_FRAC    = 14;

  // Divide by 100: x / 100 == (x * DIV_RECIP) >> DIV_SHIFT for any 32-bit x
  localparam int              DIV_NUM_W = 32;
  localparam logic [31:0]     DIV_RECIP = 32'h51EB_851F;
  localparam int              DIV_SHIFT = 37;

  // Saturation limits as magnitudes
  localparam logic [32:0] RES_POS_MAG = 33'h0_7FFF_FFFF;
  localparam logic [32:0] RES_NEG_MAG = 33'h0_8000_0000;

  // Defaults for top-level parameters
  localparam int DEF_MAX_TAPS  = 8;

  // Fixed-width window/tap index carried between controller and datapath
  localparam int IDX_W         = 5;

  // Configuration port
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 4'd0,
    REG_SCALE     = 4'd1,
    REG_TAPS_LOW  = 4'd2,
    REG_TAPS_HIGH = 4'd3
  } cfg_reg_e;

  // Beat payloads
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_sequence;
  } in_beat_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] result_value;
    logic                       final_result;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             shift_in;
    logic             clr_acc;
    logic             mac_en;
    logic [IDX_W-1:0] win_idx;
    logic [IDX_W-1:0] tap_idx;
    logic             scale_en;
    logic             div_load;
    logic             div_step;
    logic             load_out;
    logic             final_flag;
    logic             clear_hist;
  } scw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } scw_stat_t;

  // Width of the count of taps, window positions and outputs
  function automatic int cnt_bits(int max_taps);
    return $clog2(max_taps + 1);
  endfunction

endpackage

[rtl/scw_ctrl.sv]
// Sequencer: window bookkeeping, per-output MAC loop, scale, divide and output handoff.
module scw_ctrl import scw_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    eos_i,
  input  logic [TAP_CNT_BITS-1:0] tap_count_i,
  input  scw_stat_t               stat_i,
  output scw_cmd_t                cmd_o
);

  localparam int CW     = cnt_bits(MAX_TAPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SCALE,
    S_DIVLD,
    S_DIV,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   seen_q;
  logic [CW-1:0]   n_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   p_q;
  logic [CW-1:0]   k_q;
  logic            eos_q;

  logic            accept;
  logic [CW-1:0]   k_use;
  logic [CW-1:0]   held;
  logic [CW-1:0]   n_new;
  logic [CW-1:0]   cnt_new;
  logic [CW-1:0]   k_last;
  logic [CW-1:0]   win_j;
  logic            last_out;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Effective tap count, clamped to 1..MAX_TAPS
  always_comb begin
    if (tap_count_i == '0) begin
      k_use = CW'(1);
    end else if (32'(tap_count_i) > 32'(MAX_TAPS)) begin
      k_use = CW'(MAX_TAPS);
    end else begin
      k_use = CW'(tap_count_i);
    end
  end

  // Window length and number of outputs for the incoming beat
  assign held    = (seen_q > (k_use - CW'(1))) ? (k_use - CW'(1)) : seen_q;
  assign n_new   = held + CW'(1);
  assign cnt_new = eos_i ? n_new : ((n_new == k_use) ? CW'(1) : '0);

  // Terms of output p run k = 0 .. n-p-1; sample index counts back from newest
  assign k_last   = n_q - p_q - CW'(1);
  assign win_j    = n_q - CW'(1) - p_q - k_q;
  assign last_out = ((p_q + CW'(1)) == cnt_q);

  // Datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.win_idx  = IDX_W'(win_j);
    cmd_o.tap_idx  = IDX_W'(k_q);
    case (state_q)
      S_IDLE:  cmd_o.shift_in = accept;
      S_MAC: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.clr_acc = (k_q == '0);
      end
      S_DRAIN: cmd_o.mac_en = 1'b0;
      S_SCALE: cmd_o.scale_en = 1'b1;
      S_DIVLD: cmd_o.div_load = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_OUT: begin
        cmd_o.load_out   = stat_i.out_free;
        cmd_o.final_flag = eos_q && last_out;
        cmd_o.clear_hist = stat_i.out_free && eos_q && last_out;
      end
      default: cmd_o = '0;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seen_q  <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      p_q     <= '0;
      k_q     <= '0;
      eos_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            n_q   <= n_new;
            cnt_q <= cnt_new;
            eos_q <= eos_i;
            p_q   <= '0;
            k_q   <= '0;
            if (eos_i) begin
              seen_q <= '0;
            end else if (32'(seen_q) < (MAX_TAPS - 1)) begin
              seen_q <= seen_q + CW'(1);
            end
            if (cnt_new != '0) begin
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (k_q == k_last) begin
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        S_DRAIN: state_q <= S_SCALE;
        S_SCALE: state_q <= S_DIVLD;
        S_DIVLD: state_q <= S_DIV;
        S_DIV:   state_q <= S_OUT;
        S_OUT: begin
          if (stat_i.out_free) begin
            if (last_out) begin
              state_q <= S_IDLE;
            end else begin
              p_q     <= p_q + CW'(1);
              k_q     <= '0;
              state_q <= S_MAC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/scw_dp.sv]
// Datapath: sample window, tap MAC, percent scaling, divide by 100, saturation, output register.
module scw_dp import scw_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scw_cmd_t              cmd_i,
  output scw_stat_t             stat_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SCALE_BITS-1:0] scale_i,
  input  logic [CFG_DATA_W-1:0] taps_low_i,
  input  logic [CFG_DATA_W-1:0] taps_high_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o
);

  localparam int IW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W  = PROD_W + cnt_bits(MAX_TAPS);
  localparam int SCL_W  = ACC_W + SCALE_BITS + 1;
  localparam int RP_W   = DIV_NUM_W + 32;
  localparam int QUO_W  = RP_W - DIV_SHIFT;
  localparam int QX_W   = 33;

  // Pick tap k from the packed registers; taps past the eighth are zero
  function automatic logic signed [TAP_BITS-1:0] tap_pick(
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi,
    input logic [IDX_W-1:0]      k
  );
    logic [CFG_DATA_W-1:0] word;
    word = k[2] ? hi : lo;
    if (32'(k) >= CFG_TAPS) begin
      return '0;
    end
    return word[TAP_BITS*k[1:0] +: TAP_BITS];
  endfunction

  logic signed [SAMPLE_BITS-1:0] win_q [MAX_TAPS];
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [PROD_W-1:0]      prod_d;
  logic                          prod_vld_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [SCL_W-1:0]       scl_q;
  logic signed [SCL_W-1:0]       scl_d;
  logic                          neg_q;
  logic [SCL_W-1:0]              mag;
  logic [DIV_NUM_W-1:0]          num_q;
  logic [RP_W-1:0]               recip_prod;
  logic [QUO_W-1:0]              quo_q;
  logic [QX_W-1:0]               q_ext;
  logic [RES_BITS-1:0]           res_d;
  logic                          out_valid_q;
  out_beat_t                     out_q;

  logic signed [SAMPLE_BITS-1:0] win_smp;
  logic signed [TAP_BITS-1:0]    tap_sel;
  logic signed [SCALE_BITS:0]    scale_s;

  // Sample window: entry 0 is the newest, the rest is history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.clear_hist) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.shift_in) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // One product per cycle, registered ahead of the accumulator
  assign win_smp = win_q[cmd_i.win_idx[IW-1:0]];
  assign tap_sel = tap_pick(taps_low_i, taps_high_i, cmd_i.tap_idx);
  assign prod_d  = win_smp * tap_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Percent gain
  assign scale_s = {1'b0, scale_i};
  assign scl_d   = acc_q * scale_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      scl_q <= scl_d;
    end
  end

  // Magnitude, drop the Q2.14 fraction, then divide by 100 with a reciprocal multiply;
  // the magnitude after the shift always fits in 32 bits
  assign mag        = scl_q[SCL_W-1] ? SCL_W'(-scl_q) : SCL_W'(scl_q);
  assign recip_prod = RP_W'(num_q) * RP_W'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q <= scl_q[SCL_W-1];
      num_q <= DIV_NUM_W'(mag[SCL_W-1:SCALE_FRAC]);
    end
    if (cmd_i.div_step) begin
      quo_q <= recip_prod[RP_W-1:DIV_SHIFT];
    end
  end

  // Sign restore and saturation to 32 bits
  assign q_ext = QX_W'(quo_q);

  always_comb begin
    if (!neg_q) begin
      res_d = (q_ext > QX_W'(RES_POS_MAG)) ? RES_POS_MAG[RES_BITS-1:0] : q_ext[RES_BITS-1:0];
    end else if (q_ext > QX_W'(RES_NEG_MAG)) begin
      res_d = RES_NEG_MAG[RES_BITS-1:0];
    end else begin
      res_d = RES_BITS'(0) - q_ext[RES_BITS-1:0];
    end
  end

  // Output register: holds one beat until taken
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.result_value <= res_d;
      out_q.final_result <= cmd_i.final_flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

[rtl/scaled_window_correlation_top.sv]
// Top level of the scaled window correlator: configuration registers, sequencer and datapath.
//
// Accepts one Q8.8 sample beat at a time and returns, per window position, the
// correlation with up to eight Q2.14 taps, scaled by scale_percent/100, truncated
// toward zero and saturated to 32 bits. A beat that produces no result is only
// accepted. For each result of a beat, the shared multiplier handles one tap per
// cycle, then the steps that follow drain the accumulator, apply the gain, take
// the magnitude, divide by 100 with a reciprocal multiply and load the result
// register. A stalled result register holds the sequencer in the load step until
// it frees. A final sample produces up to n results back to back this way, n
// being the window length in use. The input stalls while an item is in flight;
// the result register lets the next beat enter while the last result still
// waits. The user must write configuration only while idle; the block itself
// does not enforce this.
module scaled_window_correlation_top import scw_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [TAP_CNT_BITS-1:0] tap_count_q;
  logic [SCALE_BITS-1:0]   scale_q;
  logic [CFG_DATA_W-1:0]   taps_low_q;
  logic [CFG_DATA_W-1:0]   taps_high_q;

  scw_cmd_t  cmd;
  scw_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_CNT_BITS'(1);
      scale_q     <= SCALE_BITS'(100);
      taps_low_q  <= '0;
      taps_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_COUNT: tap_count_q <= cfg_data_i[TAP_CNT_BITS-1:0];
        REG_SCALE:     scale_q     <= cfg_data_i[SCALE_BITS-1:0];
        REG_TAPS_LOW:  taps_low_q  <= cfg_data_i;
        REG_TAPS_HIGH: taps_high_q <= cfg_data_i;
        default:       tap_count_q <= tap_count_q;
      endcase
    end
  end

  scw_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .eos_i      (in_beat_i.end_of_sequence),
    .tap_count_i(tap_count_q),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scw_dp #(
    .MAX_TAPS(MAX_TAPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .sample_i   (in_beat_i.sample),
    .scale_i    (scale_q),
    .taps_low_i (taps_low_q),
    .taps_high_i(taps_high_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  // A result is never loaded over a beat that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded while output register busy");

  // Datapath steps are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mac_en, cmd.scale_en, cmd.div_load, cmd.div_step, cmd.load_out}))
    else $error("overlapping datapath commands");

  // While the input is open no computation is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(cmd.mac_en || cmd.scale_en || cmd.div_step || cmd.load_out))
    else $error("datapath busy while accepting input");

  // History is cleared only with the last result of a sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_hist |-> (cmd.load_out && cmd.final_flag))
    else $error("history cleared outside final result");

endmodule

[test/tb.sv]
// Self-checking testbench for scaled_window_correlation_top: directed table, then random sequences.
module tb;
  import scw_pkg::*;

  localparam int      TOTAL_BEATS = 170;
  localparam int      SETTLE      = 64;       // idle wait after the last expected result is taken
  localparam int      LIMIT       = 600000;
  localparam int      HIST_LEN    = DEF_MAX_TAPS - 1;
  localparam longint  GAIN_DIV    = 64'sd1638400;  // 100 * 2^14
  localparam longint  RES_MAX     = 64'sd2147483647;
  localparam longint  RES_MIN     = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_DATA_W-1:0]         data;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          eos;
    logic                          typed;     // expected result given in the row
    logic signed [RES_BITS-1:0]    want_value;
    logic                          want_final;
  } plan_row_t;

  // Directed plan: after reset, unit tap, gain extremes, tap count extremes,
  // short sequence, long sequence, ignored register, tap count change mid-sequence
  localparam int PLAN_LEN = 34;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b1, 1'b1, 32'sd0, 1'b1},
    '{ROW_WRITE, REG_TAPS_LOW,  64'h8000_7FFF_C000_4000, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_TAPS_HIGH, 64'h0001_FFFF_8000_7FFF, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b1, 32'sd32767, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b0, 1'b1, -32'sd32768, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh0001, 1'b1, 1'b1, 32'sd1, 1'b1},
    '{ROW_WRITE, REG_SCALE,     64'h0, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b1, 1'b1, 32'sd0, 1'b1},
    '{ROW_WRITE, REG_SCALE,     64'd255, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_TAP_COUNT, 64'd0, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sd100, 1'b0, 1'b1, 32'sd255, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'shFFFF, 1'b1, 1'b1, -32'sd2, 1'b1},
    '{ROW_WRITE, REG_TAP_COUNT, 64'd8, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sd12345, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'shFFFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh0000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh0100, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'shFF00, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_TAP_COUNT, 64'd15, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_SCALE,     64'd1, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_UNUSED,    64'hFFFF_FFFF_FFFF_FFFF, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_TAP_COUNT, 64'd3, 16'sh0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, 16'sd4660, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'h0, -16'sd4660, 1'b1, 1'b0, 32'sd0, 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_beat_t              in_beat_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_beat_t             out_beat_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor copy of the registers and the sample history
  logic [TAP_CNT_BITS-1:0]       tap_count_q;
  logic [SCALE_BITS-1:0]         scale_q;
  logic [63:0]                   taps_low_q;
  logic [63:0]                   taps_high_q;
  logic signed [SAMPLE_BITS-1:0] history [HIST_LEN];
  int                            held_count;

  out_beat_t window_out [DEF_MAX_TAPS];
  out_beat_t pending_results [$];
  int        mismatches;
  int        beats_sent;
  int        cycles;
  logic      calm;

  scaled_window_correlation_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 200) $display("MISMATCH %s: got %0d want %0d", what, got, want);
  endtask

  function automatic logic signed [TAP_BITS-1:0] tap_at(input int k);
    logic [63:0] word;
    word = (k < 4) ? taps_low_q : taps_high_q;
    return word[16 * (k % 4) +: 16];
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    case (idx)
      REG_TAP_COUNT: tap_count_q = data[TAP_CNT_BITS-1:0];
      REG_SCALE:     scale_q = data[SCALE_BITS-1:0];
      REG_TAPS_LOW:  taps_low_q = data;
      REG_TAPS_HIGH: taps_high_q = data;
      default: ;
    endcase
  endfunction

  // Correlates the newest window; fills window_out and returns how many results leave
  function automatic int correlate_beat(input in_beat_t b);
    longint win [DEF_MAX_TAPS];
    longint acc, q;
    int     k_use, n, last, cnt;
    k_use = (tap_count_q == 0) ? 1 :
            (tap_count_q > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(tap_count_q);
    n = ((held_count > k_use - 1) ? k_use - 1 : held_count) + 1;
    win[n - 1] = longint'(b.sample);
    for (int m = 0; m + 1 < n; m++) win[m] = longint'(history[n - 2 - m]);
    last = b.end_of_sequence ? n : (n == k_use) ? 1 : 0;
    cnt = 0;
    for (int p = 0; p < last; p++) begin
      acc = 0;
      for (int k = 0; k < k_use && p + k < n; k++) acc += win[p + k] * longint'(tap_at(k));
      q = acc * longint'(scale_q) / GAIN_DIV;
      if (q > RES_MAX) q = RES_MAX;
      if (q < RES_MIN) q = RES_MIN;
      window_out[cnt].result_value = q[31:0];
      window_out[cnt].final_result = b.end_of_sequence && (p + 1 == last);
      cnt++;
    end
    // history keeps the newest sample first; a final sample wipes it
    if (b.end_of_sequence) begin
      foreach (history[i]) history[i] = '0;
      held_count = 0;
    end else begin
      for (int m = HIST_LEN - 1; m > 0; m--) history[m] = history[m - 1];
      history[0] = b.sample;
      if (held_count < HIST_LEN) held_count++;
    end
    return cnt;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'sh8000;
    if (r < 30) return 16'sh7FFF;
    return SAMPLE_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [63:0] pick_taps();
    logic [63:0] w;
    int          r;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 9);
      w[16 * k +: 16] = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF :
                        (r == 2) ? 16'h4000 : 16'($urandom_range(0, 65535));
    end
    return w;
  endfunction

  // Drops valid, waits for every outstanding result, then lets the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_cfg(idx, data);
  endtask

  task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic eos,
                           input logic typed, input logic signed [RES_BITS-1:0] want,
                           input logic want_final);
    in_beat_t  b;
    out_beat_t given;
    int        gap, cnt;
    b.sample = s;
    b.end_of_sequence = eos;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    cnt = correlate_beat(b);
    if (typed) begin
      given.result_value = want;
      given.final_result = want_final;
      pending_results.push_back(given);
    end else begin
      for (int i = 0; i < cnt; i++) pending_results.push_back(window_out[i]);
    end
    beats_sent++;
  endtask

  // Result checker: oldest expectation first, field by field
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag("unexpected result", out_beat_o.result_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_beat_o.result_value !== want.result_value)
          flag("result_value", out_beat_o.result_value, want.result_value);
        if (out_beat_o.final_result !== want.final_result)
          flag("final_result", out_beat_o.final_result, want.final_result);
      end
    end
  end

  // Receiver back-pressure: free runs, short stalls and a few long ones
  initial begin
    int   r, n;
    logic v;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (calm || r < 40) begin
        v = 1'b0;
        n = $urandom_range(1, 30);
      end else if (r < 90) begin
        v = 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        v = 1'b1;
        n = $urandom_range(20, 60);
      end
      @(posedge clk_i);
      out_stall_i <= v;
      repeat (n - 1) @(posedge clk_i);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          len, r;
    logic [63:0] tc;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    beats_sent  = 0;
    cycles      = 0;
    calm        = 1'b0;
    tap_count_q = 4'd1;
    scale_q     = 8'd100;
    taps_low_q  = '0;
    taps_high_q = '0;
    foreach (history[i]) history[i] = '0;
    held_count  = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        wait_idle();
        write_cfg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_beat(PLAN[i].sample, PLAN[i].eos, PLAN[i].typed, PLAN[i].want_value,
                  PLAN[i].want_final);
      end
    end

    // Random phases: new settings, then a few whole sequences
    while (beats_sent < TOTAL_BEATS) begin
      wait_idle();
      r = $urandom_range(0, 9);
      tc = (r == 0) ? 64'd1 : (r == 1) ? 64'd8 :
           (r == 2) ? 64'($urandom_range(0, 15)) : 64'($urandom_range(1, 8));
      write_cfg(REG_TAP_COUNT, tc);
      r = $urandom_range(0, 9);
      write_cfg(REG_SCALE, (r == 0) ? 64'd0 : (r == 1) ? 64'd255 : 64'($urandom_range(0, 255)));
      write_cfg(REG_TAPS_LOW, pick_taps());
      write_cfg(REG_TAPS_HIGH, pick_taps());
      if ($urandom_range(0, 4) == 0)
        write_cfg(CFG_IDX_W'($urandom_range(REG_TAPS_HIGH + 1, (1 << CFG_IDX_W) - 1)),
                  {pick_taps()});
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          // occasional tap count change inside a sequence
          if (i > 0 && $urandom_range(0, 19) == 0) begin
            wait_idle();
            write_cfg(REG_TAP_COUNT, 64'($urandom_range(0, 15)));
          end
          send_beat(pick_sample(), i == len - 1, 1'b0, '0, 1'b0);
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
